/* rtl/adc_channel_scan_sequencer_core_assert.svh */
// Assertion macros for the ADC channel scan sequencer.
// Depends on nothing; included by the top level, the only module that carries assertions.
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_CORE_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ACSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acss assertion failed");
// Next-cycle implication, disabled during reset.
`define ACSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acss assertion failed");
`else
`define ACSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ACSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/acss_pkg.sv */
// Package for the ADC channel scan sequencer: payload, state and
// configuration types, codes and constants. Depends on nothing.
`default_nettype none

package acss_pkg;

    // Longest scan chain supported by the sequencer.
    localparam int MAX_CHAIN    = 8;
    localparam int LIST_ENTRIES = 8;
    // Usable list length: the smaller of the chain limit and the list size.
    localparam logic [3:0] SCAN_CAP =
        4'((MAX_CHAIN > LIST_ENTRIES) ? LIST_ENTRIES : ((MAX_CHAIN < 1) ? 1 : MAX_CHAIN));
    // Highest valid converter input.
    localparam logic [7:0] CHAN_MAX = 8'd31;

    // Request codes.
    localparam logic [1:0] REQ_SINGLE   = 2'd0;
    localparam logic [1:0] REQ_SCAN     = 2'd1;
    localparam logic [1:0] REQ_DONE     = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CH  = 2'd1;
    localparam logic [1:0] STATUS_BUSY    = 2'd2;
    localparam logic [1:0] STATUS_IGNORED = 2'd3;

    // Configuration register indexes.
    localparam logic REG_SCAN_LENGTH   = 1'b0;
    localparam logic REG_SCAN_CHANNELS = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] channel;
        logic [9:0] sample;
    } acss_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] mux_select;
        logic       start_conv;
        logic       sample_valid;
        logic [2:0] sample_index;
        logic [9:0] sample_out;
        logic       done_res;
    } acss_out_t;

    typedef struct packed {
        logic       busy;
        logic       scan_mode;
        logic [2:0] scan_position;
    } acss_state_t;

    typedef struct packed {
        logic [3:0]  scan_length;
        logic [39:0] scan_channels;
    } acss_cfg_t;

endpackage

`default_nettype wire

/* rtl/acss_cfg_regs.sv */
// Configuration registers of the ADC channel scan sequencer.
// Depends on acss_pkg.
`default_nettype none

module acss_cfg_regs (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_index,
    input  wire  [39:0]         cfg_data,
    output acss_pkg::acss_cfg_t cfg
);

    logic [3:0]  scan_length_reg;
    logic [39:0] scan_channels_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file update on each write transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_length_reg   <= 4'd1;
            scan_channels_reg <= 40'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                acss_pkg::REG_SCAN_LENGTH:   scan_length_reg   <= cfg_data[3:0];
                acss_pkg::REG_SCAN_CHANNELS: scan_channels_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.scan_length   = scan_length_reg;
    assign cfg.scan_channels = scan_channels_reg;

endmodule

`default_nettype wire

/* rtl/acss_step_logic.sv */
// Event decode for the ADC channel scan sequencer: result item and next
// sequencer state for one event. Depends on acss_pkg.
`default_nettype none

module acss_step_logic (
    input  wire acss_pkg::acss_in_t    item,
    input  wire acss_pkg::acss_state_t state_cur,
    input  wire acss_pkg::acss_cfg_t   cfg,
    output acss_pkg::acss_out_t        result,
    output acss_pkg::acss_state_t      state_nxt
);

    logic [3:0] eff_length;
    logic [3:0] next_pos;
    logic [2:0] next_idx;
    logic [4:0] entry_next;
    logic [4:0] entry_first;

    // Clamp the programmed length into 1..SCAN_CAP.
    always_comb begin
        if (cfg.scan_length == 4'd0) begin
            eff_length = 4'd1;
        end else if (cfg.scan_length > acss_pkg::SCAN_CAP) begin
            eff_length = acss_pkg::SCAN_CAP;
        end else begin
            eff_length = cfg.scan_length;
        end
    end

    // Next list position and the channel numbers read from the list.
    assign next_pos    = {1'b0, state_cur.scan_position} + 4'd1;
    assign next_idx    = next_pos[2:0];
    assign entry_next  = cfg.scan_channels[5 * next_idx +: 5];
    assign entry_first = cfg.scan_channels[4:0];

    // Event handling.
    always_comb begin
        result    = '0;
        state_nxt = state_cur;
        case (item.req_type)
            acss_pkg::REQ_SINGLE: begin
                if (item.channel > acss_pkg::CHAN_MAX) begin
                    result.status = acss_pkg::STATUS_BAD_CH;
                end else if (state_cur.busy) begin
                    result.status = acss_pkg::STATUS_BUSY;
                end else begin
                    state_nxt.busy     = 1'b1;
                    state_nxt.scan_mode = 1'b0;
                    result.mux_select  = item.channel[4:0];
                    result.start_conv  = 1'b1;
                end
            end
            acss_pkg::REQ_SCAN: begin
                if (state_cur.busy) begin
                    result.status = acss_pkg::STATUS_BUSY;
                end else begin
                    state_nxt.busy          = 1'b1;
                    state_nxt.scan_mode     = 1'b1;
                    state_nxt.scan_position = 3'd0;
                    result.mux_select       = entry_first;
                    result.start_conv       = 1'b1;
                end
            end
            acss_pkg::REQ_DONE: begin
                if (!state_cur.busy) begin
                    result.status = acss_pkg::STATUS_IGNORED;
                end else begin
                    result.sample_valid = 1'b1;
                    result.sample_out   = item.sample;
                    if (!state_cur.scan_mode) begin
                        result.done_res = 1'b1;
                        state_nxt.busy  = 1'b0;
                    end else begin
                        result.sample_index     = state_cur.scan_position;
                        state_nxt.scan_position = next_idx;
                        if (next_pos >= eff_length) begin
                            // Last entry of the scan: report and go idle.
                            result.done_res = 1'b1;
                            state_nxt.busy  = 1'b0;
                        end else begin
                            result.mux_select = entry_next;
                            result.start_conv = 1'b1;
                        end
                    end
                end
            end
            default: begin
                result.status = acss_pkg::STATUS_IGNORED;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/adc_channel_scan_sequencer_core.sv */
// Top level of the ADC channel scan sequencer: input register, event
// decode, result register and sequencer state. Depends on acss_pkg,
// acss_cfg_regs, acss_step_logic and the assertion macro header.
//
// Usage:
//   Events (start single, start scan, conversion complete) arrive on the s_
//   valid/ready channel; every event yields exactly one result item on the
//   m_ valid/ready channel, carrying status, mux select, start pulse and,
//   for completions, the sample with its list index and a last flag.
//   The cfg_ channel writes scan_length (index 0) and scan_channels
//   (index 1); it is always ready and must be used while the block is idle.
//   An event taken into the input register is decoded and lands in the
//   result register once that register is free, and m_valid then rises.
//   Throughput is one event per cycle while m_ready stays high,
//   limited only by the single decode stage between the two registers.
//   When the receiver stalls, the result register holds, the input register
//   fills behind it, and s_ready then drops until m_ready returns.
//   Reset empties both registers, returns the sequencer to idle in single
//   mode at list position 0, and sets scan_length 1 and scan_channels 0.
`default_nettype none
`include "adc_channel_scan_sequencer_core_assert.svh"

module adc_channel_scan_sequencer_core (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire acss_pkg::acss_in_t s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output acss_pkg::acss_out_t     m_data,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire                     cfg_index,
    input  wire  [39:0]             cfg_data
);

    acss_pkg::acss_cfg_t   cfg;
    acss_pkg::acss_in_t    in_data_reg;
    logic                  in_valid_reg;
    acss_pkg::acss_out_t   out_data_reg;
    logic                  out_valid_reg;
    acss_pkg::acss_state_t state_reg;
    acss_pkg::acss_state_t state_next;
    acss_pkg::acss_out_t   result;
    logic                  out_free;
    logic                  advance;

    acss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    acss_step_logic u_step (
        .item      (in_data_reg),
        .state_cur (state_reg),
        .cfg       (cfg),
        .result    (result),
        .state_nxt (state_next)
    );

    // Flow control between the two register stages.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // Sequencer state advances once per decoded event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A started conversion is always an accepted event.
    `ACSS_ASSERT_SAME(a_start_ok, aclk, aresetn, m_valid && m_data.start_conv, m_data.status == acss_pkg::STATUS_OK)
    // A completion either restarts the converter or ends the run.
    `ACSS_ASSERT_SAME(a_sample_end, aclk, aresetn, m_valid && m_data.sample_valid, m_data.done_res != m_data.start_conv)
    // Starting a conversion leaves the sequencer busy.
    `ACSS_ASSERT_NEXT(a_start_busy, aclk, aresetn, advance && result.start_conv, state_reg.busy)
    // The last result returns the sequencer to idle.
    `ACSS_ASSERT_NEXT(a_done_idle, aclk, aresetn, advance && result.done_res, !state_reg.busy)

endmodule

`default_nettype wire
